@@ sv/scgcr_pkg.sv @@
// Shared types, widths and register codes of the scan geometry column remap core.
package scgcr_pkg;

    localparam int ROW_W     = 16;
    localparam int OFF_W     = 13;
    localparam int COL_W     = 15;
    localparam int HALF_W    = 14;
    localparam int STEP_W    = 32;
    localparam int T_W       = OFF_W + STEP_W;
    localparam int G2_W      = 2 * STEP_W;
    localparam int T2_W      = 2 * T_W;
    localparam int R_W       = G2_W + T2_W;
    localparam int B_W       = T2_W + 1 + 32;
    localparam int ROOT_BITS = 16;
    localparam int P_W       = B_W + ROOT_BITS;
    localparam int CMP_W     = R_W + 2;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_HALF_WIDTH = 3'd0,
        CFG_DST_HALF_WIDTH = 3'd1,
        CFG_OUT_WIDTH      = 3'd2,
        CFG_IMAGE_HEIGHT   = 3'd3,
        CFG_TAN_STEP       = 3'd4,
        CFG_SRC_GAIN       = 3'd5,
        CFG_NORTH_FLIP     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [HALF_W-1:0] src_half_width;
        logic [HALF_W-1:0] dst_half_width;
        logic [COL_W-1:0]  out_width;
        logic [ROW_W-1:0]  image_height;
        logic [STEP_W-1:0] tan_step;
        logic [STEP_W-1:0] src_gain;
        logic              north_flip;
    } cfg_t;

    // Per-item side data that travels down the pipeline with the valid bit.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [OFF_W-1:0] off;
        logic             last;
    } item_t;

endpackage

@@ sv/scgcr_front.sv @@
// Multiplier stages that form the squared numerator and the scaled denominator.
module scgcr_front
    import scgcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  item_t             in_item,
    output logic              out_valid,
    output item_t             out_item,
    output logic [R_W-1:0]    out_r,
    output logic [B_W-1:0]    out_b
);

    logic [5:0]       v_reg;
    item_t            it_reg [6];

    logic [T_W-1:0]   t_reg;
    logic [G2_W-1:0]  g2_reg, g2b_reg, g2c_reg;
    logic [63:0]      ll_reg;
    logic [T_W-1:0]   hl_reg;
    logic [25:0]      hh_reg;
    logic [T2_W-1:0]  t2_reg;
    logic [63:0]      p00_reg, p01_reg, p02_reg, p10_reg, p11_reg, p12_reg;
    logic [B_W-1:0]   b4_reg, b5_reg, b6_reg;
    logic [63:0]      s0_reg, s3_reg;
    logic [64:0]      s1_reg, s2_reg;
    logic [R_W-1:0]   r_reg;

    logic [T_W-1:0]   t_next;
    logic [G2_W-1:0]  g2_next;
    logic [31:0]      t2_p0, t2_p1, t2_p2;
    logic [T2_W-1:0]  t2_next;
    logic [B_W-1:0]   b_next;
    logic [R_W-1:0]   r_next;

    assign t_next  = {{(T_W-OFF_W){1'b0}}, in_item.off} * {{OFF_W{1'b0}}, cfg.tan_step};
    assign g2_next = {32'd0, cfg.src_gain} * {32'd0, cfg.src_gain};
    assign t2_next = T2_W'(ll_reg) + (T2_W'(hl_reg) << 33) + (T2_W'(hh_reg) << 64);
    assign t2_p0   = t2_reg[31:0];
    assign t2_p1   = t2_reg[63:32];
    assign t2_p2   = {6'd0, t2_reg[T2_W-1:64]};
    assign b_next  = (B_W'(t2_reg) + (B_W'(1) << 64)) << 32;
    assign r_next  = R_W'(s0_reg) + (R_W'(s1_reg) << 32) + (R_W'(s2_reg) << 64)
                   + (R_W'(s3_reg) << 96);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg[0] <= in_item;
        for (int s = 1; s < 6; s++)
        begin
            it_reg[s] <= it_reg[s-1];
        end
        t_reg   <= t_next;
        g2_reg  <= g2_next;
        ll_reg  <= {32'd0, t_reg[31:0]} * {32'd0, t_reg[31:0]};
        hl_reg  <= {{(T_W-OFF_W){1'b0}}, t_reg[T_W-1:32]} * {{OFF_W{1'b0}}, t_reg[31:0]};
        hh_reg  <= {13'd0, t_reg[T_W-1:32]} * {13'd0, t_reg[T_W-1:32]};
        g2b_reg <= g2_reg;
        t2_reg  <= t2_next;
        g2c_reg <= g2b_reg;
        p00_reg <= {32'd0, g2c_reg[31:0]}  * {32'd0, t2_p0};
        p01_reg <= {32'd0, g2c_reg[31:0]}  * {32'd0, t2_p1};
        p02_reg <= {32'd0, g2c_reg[31:0]}  * {32'd0, t2_p2};
        p10_reg <= {32'd0, g2c_reg[63:32]} * {32'd0, t2_p0};
        p11_reg <= {32'd0, g2c_reg[63:32]} * {32'd0, t2_p1};
        p12_reg <= {32'd0, g2c_reg[63:32]} * {32'd0, t2_p2};
        b4_reg  <= b_next;
        s0_reg  <= p00_reg;
        s1_reg  <= 65'(p01_reg) + 65'(p10_reg);
        s2_reg  <= 65'(p02_reg) + 65'(p11_reg);
        s3_reg  <= p12_reg;
        b5_reg  <= b4_reg;
        r_reg   <= r_next;
        b6_reg  <= b5_reg;
    end

    assign out_valid = v_reg[5];
    assign out_item  = it_reg[5];
    assign out_r     = r_reg;
    assign out_b     = b6_reg;

endmodule

@@ sv/scgcr_root.sv @@
// Bit-per-stage search for the largest offset whose square times the denominator fits under the numerator.
module scgcr_root
    import scgcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  item_t                in_item,
    input  logic [R_W-1:0]       in_r,
    input  logic [B_W-1:0]       in_b,
    output logic                 out_valid,
    output item_t                out_item,
    output logic [ROOT_BITS-1:0] out_k
);

    logic                 v_reg  [ROOT_BITS];
    item_t                it_reg [ROOT_BITS];
    logic [R_W-1:0]       e_reg  [ROOT_BITS];
    logic [P_W-1:0]       p_reg  [ROOT_BITS];
    logic [B_W-1:0]       b_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] k_reg  [ROOT_BITS];

    logic                 v_src  [ROOT_BITS];
    item_t                it_src [ROOT_BITS];
    logic [R_W-1:0]       e_src  [ROOT_BITS];
    logic [P_W-1:0]       p_src  [ROOT_BITS];
    logic [B_W-1:0]       b_src  [ROOT_BITS];
    logic [ROOT_BITS-1:0] k_src  [ROOT_BITS];

    genvar s;
    generate
        for (s = 0; s < ROOT_BITS; s++)
        begin : g_stage
            localparam int J = ROOT_BITS - 1 - s;
            logic [CMP_W-1:0] d;
            logic             take;

            if (s == 0)
            begin : g_first
                assign v_src[s]  = in_valid;
                assign it_src[s] = in_item;
                assign e_src[s]  = in_r;
                assign p_src[s]  = '0;
                assign b_src[s]  = in_b;
                assign k_src[s]  = '0;
            end
            else
            begin : g_next
                assign v_src[s]  = v_reg[s-1];
                assign it_src[s] = it_reg[s-1];
                assign e_src[s]  = e_reg[s-1];
                assign p_src[s]  = p_reg[s-1];
                assign b_src[s]  = b_reg[s-1];
                assign k_src[s]  = k_reg[s-1];
            end

            // Raising bit J adds (2^(J+1) k + 2^(2J)) times the denominator.
            assign d    = (CMP_W'(p_src[s]) << (J + 1)) + (CMP_W'(b_src[s]) << (2 * J));
            assign take = d <= CMP_W'(e_src[s]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else
                begin
                    v_reg[s] <= v_src[s];
                end
            end

            always_ff @(posedge clk)
            begin
                it_reg[s] <= it_src[s];
                b_reg[s]  <= b_src[s];
                if (take)
                begin
                    e_reg[s] <= e_src[s] - d[R_W-1:0];
                    p_reg[s] <= p_src[s] + (P_W'(b_src[s]) << J);
                    k_reg[s] <= k_src[s] | (ROOT_BITS'(1) << J);
                end
                else
                begin
                    e_reg[s] <= e_src[s];
                    p_reg[s] <= p_src[s];
                    k_reg[s] <= k_src[s];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ROOT_BITS-1];
    assign out_item  = it_reg[ROOT_BITS-1];
    assign out_k     = k_reg[ROOT_BITS-1];

endmodule

@@ sv/scgcr_back.sv @@
// Output stage that forms the destination and source coordinates.
module scgcr_back
    import scgcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    input  item_t                   in_item,
    input  logic [ROOT_BITS-1:0]    in_k,
    output logic                    done,
    output logic [COL_W-1:0]        right_dest_col,
    output logic signed [COL_W-1:0] right_src_col,
    output logic [COL_W-1:0]        left_dest_col,
    output logic signed [COL_W-1:0] left_src_col,
    output logic [ROW_W-1:0]        src_row
);

    logic                    done_reg;
    logic [COL_W-1:0]        rd_reg, ld_reg;
    logic signed [COL_W-1:0] rs_reg, ls_reg;
    logic [ROW_W-1:0]        row_reg;

    logic [COL_W-1:0] k, rd, ld, z, a, i;

    assign k  = in_item.last ? '0 : in_k[COL_W-1:0];
    assign z  = COL_W'(cfg.dst_half_width);
    assign a  = COL_W'(cfg.src_half_width);
    assign i  = COL_W'(in_item.off);
    assign rd = z + i - COL_W'(1);
    assign ld = z - i;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg  <= cfg.north_flip ? cfg.out_width - rd : rd;
        ld_reg  <= cfg.north_flip ? cfg.out_width - ld : ld;
        row_reg <= cfg.north_flip ? cfg.image_height - in_item.row : in_item.row;
        rs_reg  <= a + k - COL_W'(1);
        ls_reg  <= a - k;
    end

    assign done           = done_reg;
    assign right_dest_col = rd_reg;
    assign right_src_col  = rs_reg;
    assign left_dest_col  = ld_reg;
    assign left_src_col   = ls_reg;
    assign src_row        = row_reg;

endmodule

@@ sv/scan_geometry_column_remap_core.sv @@
// Top level of the scan geometry column remap core: registers and pipeline.
//
// One pixel request is taken in every clock cycle: busy never rises, so a transfer
// completes whenever start is high. Each request yields exactly one result, shown
// with done for a single cycle at the end of the pipeline; the receiver cannot
// hold results off, and none is needed since the pipeline never stalls. It holds
// six multiplier stages that build the squared numerator g^2 T^2 and the
// denominator 2^32 (2^64 + T^2), sixteen search stages that each settle one bit
// of the source offset k with a shift, an add and a compare, and one output
// stage that forms the coordinates. Configuration writes are always ready and take
// effect at once, so they should be made only while no request is in flight. The
// last column offset, dst_half_width minus one, gives a source offset of zero.
module scan_geometry_column_remap_core
    import scgcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ROW_W-1:0]        out_row,
    input  logic [OFF_W-1:0]        col_offset,
    output logic                    done,
    output logic [COL_W-1:0]        right_dest_col,
    output logic signed [COL_W-1:0] right_src_col,
    output logic [COL_W-1:0]        left_dest_col,
    output logic signed [COL_W-1:0] left_src_col,
    output logic [ROW_W-1:0]        src_row,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_data
);

    cfg_t  cfg_reg;
    item_t in_item;
    logic  in_valid;

    logic              f_valid;
    item_t             f_item;
    logic [R_W-1:0]    f_r;
    logic [B_W-1:0]    f_b;
    logic                 q_valid;
    item_t                q_item;
    logic [ROOT_BITS-1:0] q_k;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    // The last offset is flagged on entry; a zero half width never matches.
    assign in_item.row  = out_row;
    assign in_item.off  = col_offset;
    assign in_item.last = (HALF_W'(col_offset) + HALF_W'(1)) == cfg_reg.dst_half_width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_half_width <= HALF_W'(784);
            cfg_reg.dst_half_width <= HALF_W'(1024);
            cfg_reg.out_width      <= COL_W'(2048);
            cfg_reg.image_height   <= ROW_W'(1024);
            cfg_reg.tan_step       <= 32'd4194304;
            cfg_reg.src_gain       <= 32'd51380224;
            cfg_reg.north_flip     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SRC_HALF_WIDTH: cfg_reg.src_half_width <= cfg_data[HALF_W-1:0];
                CFG_DST_HALF_WIDTH: cfg_reg.dst_half_width <= cfg_data[HALF_W-1:0];
                CFG_OUT_WIDTH:      cfg_reg.out_width      <= cfg_data[COL_W-1:0];
                CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[ROW_W-1:0];
                CFG_TAN_STEP:       cfg_reg.tan_step       <= cfg_data;
                CFG_SRC_GAIN:       cfg_reg.src_gain       <= cfg_data;
                CFG_NORTH_FLIP:     cfg_reg.north_flip     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    scgcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_r     (f_r),
        .out_b     (f_b)
    );

    scgcr_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .in_r      (f_r),
        .in_b      (f_b),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_k     (q_k)
    );

    scgcr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (q_valid),
        .in_item        (q_item),
        .in_k           (q_k),
        .done           (done),
        .right_dest_col (right_dest_col),
        .right_src_col  (right_src_col),
        .left_dest_col  (left_dest_col),
        .left_src_col   (left_src_col),
        .src_row        (src_row)
    );

endmodule

@@ sv/scgcr_checker.sv @@
// Port-level checks of the scan geometry column remap core and their binding.
module scgcr_checker
    import scgcr_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic signed [COL_W-1:0] right_src_col,
    input logic signed [COL_W-1:0] left_src_col
);

    localparam int LATENCY = 23;

    logic [COL_W-1:0] src_diff;
    assign src_diff = right_src_col - left_src_col;

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline never stalls");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted request produced no result after the pipeline latency");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    a_src_spread_odd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> src_diff[0])
        else $error("right and left source columns do not differ by 2k-1");

endmodule

bind scan_geometry_column_remap_core scgcr_checker u_scgcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .right_src_col (right_src_col),
    .left_src_col  (left_src_col)
);
